@@ rtl/core/jls_pkg.sv @@
// ----------------------------------------------------------------------------
// jls_pkg
// Shared constants, types and helpers for the Jacobi linear solver.
// ----------------------------------------------------------------------------
`default_nettype none

package jls_pkg;

    localparam int MAX_UNKNOWNS = 16;
    localparam int VALUE_BITS   = 32;
    localparam int FRAC_BITS    = 16;
    localparam int ROW_LEN      = MAX_UNKNOWNS + 1;
    localparam int MEM_DEPTH    = MAX_UNKNOWNS * ROW_LEN;
    localparam int IDX_W        = $clog2(MAX_UNKNOWNS);
    localparam int COL_W        = $clog2(MAX_UNKNOWNS + 1);
    localparam int ADDR_W       = $clog2(MEM_DEPTH);
    localparam int PROD_W       = 2 * VALUE_BITS;
    localparam int TERM_W       = PROD_W - FRAC_BITS;
    localparam int ACC_W        = TERM_W + COL_W + 1;
    localparam int DIVD_W       = VALUE_BITS + FRAC_BITS;
    localparam int DCNT_W       = $clog2(DIVD_W + 1);
    localparam int CNT_W        = 16;
    localparam int STATUS_W     = 2;
    localparam int TOL_W        = 31;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 31;

    localparam int S_FIELDS_W   = IDX_W + COL_W + VALUE_BITS;
    localparam int S_TDATA_W    = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_FIELDS_W   = IDX_W + VALUE_BITS + STATUS_W + CNT_W;
    localparam int M_TDATA_W    = ((M_FIELDS_W + 7) / 8) * 8;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT     = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_CONVERGED = 2'd0;
    localparam logic [STATUS_W-1:0] ST_LIMIT     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ZERO_DIAG = 2'd2;

    // Divider handshake status
    typedef struct packed {
        logic busy;
        logic done;
    } jls_div_stat_t;

    // Saturate the accumulator to the signed value range
    function automatic logic signed [VALUE_BITS-1:0] sat_acc(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] vmax;
        logic signed [ACC_W-1:0] vmin;
        vmax = ACC_W'({1'b0, {(VALUE_BITS-1){1'b1}}});
        vmin = -vmax - ACC_W'(1);
        if (v > vmax)
            return VALUE_BITS'(vmax);
        else if (v < vmin)
            return VALUE_BITS'(vmin);
        else
            return VALUE_BITS'(v);
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/jacobi_linear_solver_top.sv @@
// ----------------------------------------------------------------------------
// jacobi_linear_solver_top
// Jacobi solver for up to MAX_UNKNOWNS equations in signed Q16.16.
//
// Input channel s_*: a word with s_tuser low loads one matrix entry (row,
// column) into the coefficient store, one word per cycle while idle; the
// right-hand side sits at column size_in_use. A word with s_tuser high starts
// a solve: s_tready stays low until the solve has handed its last result to
// the output register.
// A solve checks the diagonals row by row, then runs sweeps from a zero
// vector. Each row loads its right-hand side; for each other column the one
// shared multiplier forms a product that is subtracted, the diagonal is
// skipped, and the row then waits on the restoring divider for its quotient.
// A sweep runs the n rows and a closing step; sweeps repeat until the
// largest change is at or below the tolerance or the iteration limit.
// Output channel m_*: n result words, m_tlast on the last; a stalled receiver
// holds the sequencer in the emit step. Config port cfg_* is always ready.
// Reset clears the sequencer and loads register defaults; the coefficient
// store is not cleared, and entries must be loaded before a solve reads them.
// ----------------------------------------------------------------------------
`default_nettype none

module jacobi_linear_solver_top
(
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    // s_tdata: row[3:0], column[8:4], coefficient[40:9]
    input  wire logic [jls_pkg::S_TDATA_W-1:0]    s_tdata,
    // s_tuser: kind[0]
    input  wire logic                             s_tuser,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // m_tdata: unknown_index[3:0], solution_value[35:4], status[37:36],
    //          sweeps_done[53:38]
    output logic [jls_pkg::M_TDATA_W-1:0]         m_tdata,
    output logic                                  m_tlast,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [jls_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [jls_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import jls_pkg::*;

    typedef enum logic [12:0] {
        S_IDLE      = 13'b0000000000001,
        S_DIAG_RD   = 13'b0000000000010,
        S_DIAG_CHK  = 13'b0000000000100,
        S_RHS_RD    = 13'b0000000001000,
        S_RHS_LD    = 13'b0000000010000,
        S_EL_RD     = 13'b0000000100000,
        S_EL_MUL    = 13'b0000001000000,
        S_EL_ACC    = 13'b0000010000000,
        S_DIV_RD    = 13'b0000100000000,
        S_DIV_GO    = 13'b0001000000000,
        S_DIV_WAIT  = 13'b0010000000000,
        S_SWEEP_END = 13'b0100000000000,
        S_EMIT      = 13'b1000000000000
    } state_t;

    state_t                        state_reg;

    // Configuration registers
    logic [TOL_W-1:0]              tol_reg;
    logic [COL_W-1:0]              size_reg;
    logic [CNT_W-1:0]              limit_reg;
    logic [COL_W-1:0]              n_eff;
    logic [COL_W-1:0]              n_m1;
    logic [CNT_W-1:0]              limit_eff;

    // Sequencer state
    logic [IDX_W-1:0]              i_reg;
    logic [COL_W-1:0]              j_reg;
    logic                          bank_reg;
    logic                          first_reg;
    logic                          zdiag_reg;
    logic [STATUS_W-1:0]           status_reg;
    logic [CNT_W-1:0]              cnt_reg;
    logic [CNT_W-1:0]              cnt_next;
    logic [VALUE_BITS:0]           worst_reg;

    // Datapath
    logic signed [ACC_W-1:0]       acc_reg;
    logic signed [PROD_W-1:0]      prod_reg;
    logic signed [VALUE_BITS-1:0]  prev_d_reg;
    logic signed [VALUE_BITS-1:0]  prev_i_reg;
    logic signed [VALUE_BITS-1:0]  vec_reg [2][MAX_UNKNOWNS];
    logic signed [VALUE_BITS-1:0]  vec_rd;
    logic [IDX_W-1:0]              vec_addr;
    logic signed [PROD_W-1:0]      rnd_prod;
    logic signed [TERM_W-1:0]      term;
    logic signed [VALUE_BITS:0]    diff;
    logic [VALUE_BITS:0]           delta;

    // Coefficient store
    logic signed [VALUE_BITS-1:0]  mem [MEM_DEPTH];
    logic signed [VALUE_BITS-1:0]  rdata_reg;
    logic [ADDR_W-1:0]             row_base;
    logic [COL_W-1:0]              rd_col;
    logic [ADDR_W-1:0]             rd_addr;
    logic [ADDR_W-1:0]             wr_addr;
    logic                          wr_en;

    // Input fields
    logic [IDX_W-1:0]              in_row;
    logic [COL_W-1:0]              in_col;
    logic signed [VALUE_BITS-1:0]  in_coef;
    logic                          s_fire;

    // Divider
    logic                          div_start;
    logic signed [DIVD_W-1:0]      div_dividend;
    jls_div_stat_t                 div_stat;
    logic signed [VALUE_BITS-1:0]  div_q;

    // Output register
    logic [M_TDATA_W-1:0]          m_tdata_reg;
    logic                          m_tlast_reg;
    logic                          m_tvalid_reg;
    logic                          out_load;
    logic                          last_out;

    // Effective sizes
    assign n_eff     = (size_reg == '0) ? COL_W'(1) :
                       (size_reg > COL_W'(MAX_UNKNOWNS)) ? COL_W'(MAX_UNKNOWNS) : size_reg;
    assign n_m1      = n_eff - COL_W'(1);
    assign limit_eff = (limit_reg == '0) ? CNT_W'(1) : limit_reg;
    assign cnt_next  = cnt_reg + CNT_W'(1);

    // Configuration writes
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg   <= TOL_W'(66);
            size_reg  <= COL_W'(MAX_UNKNOWNS);
            limit_reg <= CNT_W'(1000);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_TOLERANCE: tol_reg   <= cfg_data[TOL_W-1:0];
                CFG_SIZE:      size_reg  <= cfg_data[COL_W-1:0];
                CFG_LIMIT:     limit_reg <= cfg_data[CNT_W-1:0];
                default:       ;
            endcase
        end
    end

    // Unpack input word
    assign in_row  = s_tdata[IDX_W-1:0];
    assign in_col  = s_tdata[IDX_W +: COL_W];
    assign in_coef = s_tdata[IDX_W+COL_W +: VALUE_BITS];
    assign s_tready = (state_reg == S_IDLE);
    assign s_fire   = s_tvalid && s_tready;

    // Store addressing
    assign wr_addr = ADDR_W'(in_row) * ADDR_W'(ROW_LEN) + ADDR_W'(in_col);
    assign wr_en   = s_fire && !s_tuser && (in_col <= COL_W'(MAX_UNKNOWNS));
    assign row_base = ADDR_W'(i_reg) * ADDR_W'(ROW_LEN);

    always_comb
    begin
        rd_col = COL_W'(i_reg);
        if (state_reg == S_RHS_RD)
            rd_col = n_eff;
        else if (state_reg == S_EL_RD)
            rd_col = j_reg;
    end

    assign rd_addr = row_base + ADDR_W'(rd_col);

    // Coefficient store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= in_coef;
        rdata_reg <= mem[rd_addr];
    end

    // Vector read port: element index during sweeps, result index on emit
    assign vec_addr = (state_reg == S_EMIT) ? i_reg : j_reg[IDX_W-1:0];
    assign vec_rd   = first_reg ? '0 : vec_reg[bank_reg][vec_addr];

    // Shared multiplier result, rounded to Q16.16
    assign rnd_prod = prod_reg + PROD_W'(1 << (FRAC_BITS - 1));
    assign term     = TERM_W'(rnd_prod >>> FRAC_BITS);

    // Change of the finished entry
    assign diff  = (VALUE_BITS+1)'(div_q) - (VALUE_BITS+1)'(prev_i_reg);
    assign delta = diff[VALUE_BITS] ? (VALUE_BITS+1)'(-diff) : (VALUE_BITS+1)'(diff);

    assign div_start    = (state_reg == S_DIV_GO);
    assign div_dividend = {sat_acc(acc_reg), {FRAC_BITS{1'b0}}};

    jls_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (rdata_reg),
        .stat     (div_stat),
        .quotient (div_q)
    );

    // Output staging
    assign last_out = (COL_W'(i_reg) == n_m1);
    assign out_load = (state_reg == S_EMIT) && (!m_tvalid_reg || m_tready);

    // Sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            i_reg      <= '0;
            j_reg      <= '0;
            bank_reg   <= 1'b0;
            first_reg  <= 1'b1;
            zdiag_reg  <= 1'b0;
            status_reg <= ST_CONVERGED;
            cnt_reg    <= '0;
            worst_reg  <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (s_fire && s_tuser)
                    begin
                        i_reg     <= '0;
                        zdiag_reg <= 1'b0;
                        cnt_reg   <= '0;
                        state_reg <= S_DIAG_RD;
                    end
                end
                S_DIAG_RD:
                    state_reg <= S_DIAG_CHK;
                S_DIAG_CHK:
                begin
                    if (rdata_reg == '0)
                        zdiag_reg <= 1'b1;
                    if (COL_W'(i_reg) == n_m1)
                    begin
                        i_reg <= '0;
                        if (zdiag_reg || rdata_reg == '0)
                        begin
                            status_reg <= ST_ZERO_DIAG;
                            state_reg  <= S_EMIT;
                        end
                        else
                        begin
                            first_reg <= 1'b1;
                            worst_reg <= '0;
                            state_reg <= S_RHS_RD;
                        end
                    end
                    else
                    begin
                        i_reg     <= i_reg + 1'b1;
                        state_reg <= S_DIAG_RD;
                    end
                end
                S_RHS_RD:
                    state_reg <= S_RHS_LD;
                S_RHS_LD:
                begin
                    j_reg     <= '0;
                    state_reg <= S_EL_RD;
                end
                S_EL_RD:
                begin
                    if (j_reg == COL_W'(i_reg))
                    begin
                        // Skip the diagonal, keep the old value of this entry
                        if (j_reg == n_m1)
                            state_reg <= S_DIV_RD;
                        else
                            j_reg <= j_reg + 1'b1;
                    end
                    else
                    begin
                        state_reg <= S_EL_MUL;
                    end
                end
                S_EL_MUL:
                    state_reg <= S_EL_ACC;
                S_EL_ACC:
                begin
                    if (j_reg == n_m1)
                        state_reg <= S_DIV_RD;
                    else
                    begin
                        j_reg     <= j_reg + 1'b1;
                        state_reg <= S_EL_RD;
                    end
                end
                S_DIV_RD:
                    state_reg <= S_DIV_GO;
                S_DIV_GO:
                    state_reg <= S_DIV_WAIT;
                S_DIV_WAIT:
                begin
                    if (div_stat.done)
                    begin
                        if (delta > worst_reg)
                            worst_reg <= delta;
                        if (COL_W'(i_reg) == n_m1)
                            state_reg <= S_SWEEP_END;
                        else
                        begin
                            i_reg     <= i_reg + 1'b1;
                            state_reg <= S_RHS_RD;
                        end
                    end
                end
                S_SWEEP_END:
                begin
                    cnt_reg   <= cnt_next;
                    bank_reg  <= !bank_reg;
                    first_reg <= 1'b0;
                    i_reg     <= '0;
                    if (worst_reg <= (VALUE_BITS+1)'(tol_reg))
                    begin
                        status_reg <= ST_CONVERGED;
                        state_reg  <= S_EMIT;
                    end
                    else if (cnt_next >= limit_eff)
                    begin
                        status_reg <= ST_LIMIT;
                        state_reg  <= S_EMIT;
                    end
                    else
                    begin
                        worst_reg <= '0;
                        state_reg <= S_RHS_RD;
                    end
                end
                S_EMIT:
                begin
                    if (out_load)
                    begin
                        if (last_out)
                            state_reg <= S_IDLE;
                        else
                            i_reg <= i_reg + 1'b1;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (state_reg == S_RHS_LD)
            acc_reg <= ACC_W'(rdata_reg);
        if (state_reg == S_EL_RD)
        begin
            prev_d_reg <= vec_rd;
            if (j_reg == COL_W'(i_reg))
                prev_i_reg <= vec_rd;
        end
        if (state_reg == S_EL_MUL)
            prod_reg <= PROD_W'(rdata_reg) * PROD_W'(prev_d_reg);
        if (state_reg == S_EL_ACC)
            acc_reg <= acc_reg - ACC_W'(term);
        if (state_reg == S_DIV_WAIT && div_stat.done)
            vec_reg[!bank_reg][i_reg] <= div_q;
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else if (out_load)
            m_tvalid_reg <= 1'b1;
        else if (m_tready)
            m_tvalid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            m_tdata_reg <= M_TDATA_W'({cnt_reg, status_reg,
                                       (zdiag_reg ? {VALUE_BITS{1'b0}} : vec_rd), i_reg});
            m_tlast_reg <= last_out;
        end
    end

    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tvalid = m_tvalid_reg;

    // Checks
    a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !s_tready)
        else $error("input taken during a solve");

    a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_stat.busy)
        else $error("divider started while busy");

    a_sweeps_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT) |-> (cnt_reg <= limit_eff))
        else $error("sweep count past the limit");

    a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && last_out) |=> (m_tlast && m_tdata[IDX_W-1:0] == $past(i_reg)))
        else $error("last word carries wrong index");

endmodule

`default_nettype wire

@@ rtl/core/jls_div.sv @@
// ----------------------------------------------------------------------------
// jls_div
// Restoring signed divider, one quotient bit per cycle, truncating toward
// zero, result saturated to the signed value range.
// ----------------------------------------------------------------------------
`default_nettype none

module jls_div
(
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   start,
    input  wire logic signed [jls_pkg::DIVD_W-1:0]      dividend,
    input  wire logic signed [jls_pkg::VALUE_BITS-1:0]  divisor,
    output jls_pkg::jls_div_stat_t                      stat,
    output logic signed [jls_pkg::VALUE_BITS-1:0]       quotient
);
    import jls_pkg::*;

    logic                    busy_reg;
    logic                    done_reg;
    logic                    neg_reg;
    logic [DCNT_W-1:0]       cnt_reg;
    logic [VALUE_BITS-1:0]   rem_reg;
    logic [DIVD_W-1:0]       quo_reg;
    logic [VALUE_BITS-1:0]   dvs_reg;
    logic signed [VALUE_BITS-1:0] q_reg;

    logic [VALUE_BITS:0]     trial;
    logic                    fit;
    logic signed [DIVD_W:0]  signed_q;

    // Shift in one dividend bit and try the subtract
    assign trial = {rem_reg, quo_reg[DIVD_W-1]};
    assign fit   = trial >= {1'b0, dvs_reg};

    assign signed_q = neg_reg ? -$signed({1'b0, quo_reg}) : $signed({1'b0, quo_reg});

    // Control: start, count steps, finish
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start && !busy_reg)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                if (cnt_reg == DCNT_W'(DIVD_W))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end
        end
    end

    // Datapath: magnitudes in, one quotient bit per step, signed result out
    always_ff @(posedge clk)
    begin
        if (start && !busy_reg)
        begin
            neg_reg <= dividend[DIVD_W-1] ^ divisor[VALUE_BITS-1];
            quo_reg <= dividend[DIVD_W-1] ? DIVD_W'(-dividend) : DIVD_W'(dividend);
            dvs_reg <= divisor[VALUE_BITS-1] ? VALUE_BITS'(-divisor) : VALUE_BITS'(divisor);
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (cnt_reg == DCNT_W'(DIVD_W))
            begin
                if (signed_q > $signed((DIVD_W+1)'({1'b0, {(VALUE_BITS-1){1'b1}}})))
                    q_reg <= {1'b0, {(VALUE_BITS-1){1'b1}}};
                else if (signed_q < -$signed((DIVD_W+1)'({1'b1, {(VALUE_BITS-1){1'b0}}})))
                    q_reg <= {1'b1, {(VALUE_BITS-1){1'b0}}};
                else
                    q_reg <= VALUE_BITS'(signed_q);
            end
            else
            begin
                rem_reg <= fit ? VALUE_BITS'(trial - {1'b0, dvs_reg}) : VALUE_BITS'(trial);
                quo_reg <= {quo_reg[DIVD_W-2:0], fit};
            end
        end
    end

    assign stat     = '{busy: busy_reg, done: done_reg};
    assign quotient = q_reg;

endmodule

`default_nettype wire

@@ sim/jacobi_linear_solver_top_tb.sv @@
// ----------------------------------------------------------------------------
// jacobi_linear_solver_top_tb
// Self-checking bench for the Jacobi solver: loads augmented matrices over
// the input stream, starts solves, and checks every solution word against a
// fixed-point sweep predictor kept in step with the register settings.
// ----------------------------------------------------------------------------
module jacobi_linear_solver_top_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import jls_pkg::*;

    localparam int  CYCLE_LIMIT = 1500000;
    localparam int  ITEM_TARGET = 380;
    localparam int  KIND_LOAD   = 0;
    localparam int  KIND_SOLVE  = 1;
    localparam int  FILL_RANDOM = 0;
    localparam int  FILL_DOMINANT = 1;
    localparam int  FILL_ZERO_DIAG = 2;

    typedef struct packed {
        logic        kind;
        logic [3:0]  row;
        logic [4:0]  column;
        logic [31:0] coef;
    } solver_word_t;

    typedef struct packed {
        logic [3:0]  idx;
        logic [31:0] value;
        logic [1:0]  status;
        logic [15:0] sweeps;
        logic        last;
    } solution_t;

    logic                    clk;
    logic                    rst_n;
    logic [S_TDATA_W-1:0]    s_tdata;
    logic                    s_tuser;
    logic                    s_tvalid;
    logic                    s_tready;
    logic [M_TDATA_W-1:0]    m_tdata;
    logic                    m_tlast;
    logic                    m_tvalid;
    logic                    m_tready;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [CFG_IDX_W-1:0]    cfg_index;
    logic [CFG_DATA_W-1:0]   cfg_data;

    jacobi_linear_solver_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Bench copies of the coefficient store and the registers
    longint        coef_mem [MAX_UNKNOWNS][ROW_LEN];
    logic [30:0]   tol_reg;
    logic [4:0]    size_reg;
    logic [15:0]   limit_reg;

    solver_word_t  pending_words[$];
    solution_t     expected_solutions[$];
    solver_word_t  offered;

    int            fail_count;
    int            item_count;
    int            solve_count;
    int            result_count;
    int            status_seen [3];
    int            cycle_count;
    logic          calm;
    logic          long_hold_req;
    logic          hold_done;
    int            hold_left;

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    function automatic longint sat_value(input longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    // Run Jacobi sweeps on the bench copy and queue one solution per unknown
    task automatic predict_solve();
        int      n;
        int      lim;
        int      sweeps;
        logic [1:0] status;
        longint  cur [MAX_UNKNOWNS];
        longint  prev [MAX_UNKNOWNS];
        longint  acc;
        longint  q;
        longint  delta;
        longint  worst;
        solution_t s;
        n = (size_reg == 0) ? 1 : (size_reg > MAX_UNKNOWNS) ? MAX_UNKNOWNS : size_reg;
        lim = (limit_reg == 0) ? 1 : limit_reg;
        sweeps = 0;
        status = ST_CONVERGED;
        for (int i = 0; i < MAX_UNKNOWNS; i++)
            cur[i] = 0;
        for (int i = 0; i < n; i++)
            if (coef_mem[i][i] == 0)
                status = ST_ZERO_DIAG;
        if (status != ST_ZERO_DIAG)
        begin
            forever
            begin
                worst = 0;
                prev = cur;
                for (int i = 0; i < n; i++)
                begin
                    acc = coef_mem[i][n];
                    for (int j = 0; j < n; j++)
                        if (j != i)
                            acc -= (coef_mem[i][j] * prev[j] + 64'sd32768) >>> FRAC_BITS;
                    acc = sat_value(acc);
                    q = sat_value((acc * 64'sd65536) / coef_mem[i][i]);
                    cur[i] = q;
                    delta = (q > prev[i]) ? q - prev[i] : prev[i] - q;
                    if (delta > worst)
                        worst = delta;
                end
                sweeps = (sweeps + 1) & 16'hFFFF;
                if (worst <= longint'(tol_reg))
                begin
                    status = ST_CONVERGED;
                    break;
                end
                if (sweeps >= lim)
                begin
                    status = ST_LIMIT;
                    break;
                end
            end
        end
        for (int i = 0; i < n; i++)
        begin
            s.idx    = i[3:0];
            s.value  = (status == ST_ZERO_DIAG) ? 32'd0 : cur[i][31:0];
            s.status = status;
            s.sweeps = sweeps[15:0];
            s.last   = (i == n - 1);
            expected_solutions.push_back(s);
        end
        status_seen[status]++;
        solve_count++;
    endtask

    // Offer queued words; a word is applied to the predictor when accepted
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                if (offered.kind == KIND_LOAD)
                begin
                    if (offered.column <= MAX_UNKNOWNS)
                        coef_mem[offered.row][offered.column] = longint'($signed(offered.coef));
                end
                else
                    predict_solve();
            end
            if (!s_tvalid || s_tready)
            begin
                if (pending_words.size() != 0 && (calm || $urandom_range(99) >= 15))
                begin
                    offered = pending_words.pop_front();
                    s_tdata  <= S_TDATA_W'({offered.coef, offered.column, offered.row});
                    s_tuser  <= offered.kind;
                    s_tvalid <= 1'b1;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver readiness: random stalls, plus one long hold-off on request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready  <= 1'b0;
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (long_hold_req && !hold_done)
        begin
            hold_left <= 400;
            hold_done <= 1'b1;
            m_tready  <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end
        else
            m_tready <= calm || ($urandom_range(99) >= 15);
    end

    // Compare each accepted solution word with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            solution_t got;
            solution_t want;
            got.idx    = m_tdata[3:0];
            got.value  = m_tdata[35:4];
            got.status = m_tdata[37:36];
            got.sweeps = m_tdata[53:38];
            got.last   = m_tlast;
            result_count++;
            if (expected_solutions.size() == 0)
            begin
                $error("unexpected solution word: index %0d value %h", got.idx, got.value);
                fail_count++;
            end
            else
            begin
                want = expected_solutions.pop_front();
                if (got.idx !== want.idx)
                begin
                    $error("unknown_index: expected %0d, got %0d", want.idx, got.idx);
                    fail_count++;
                end
                if (got.value !== want.value)
                begin
                    $error("solution_value: expected %h, got %h", want.value, got.value);
                    fail_count++;
                end
                if (got.status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, got.status);
                    fail_count++;
                end
                if (got.sweeps !== want.sweeps)
                begin
                    $error("sweeps_done: expected %0d, got %0d", want.sweeps, got.sweeps);
                    fail_count++;
                end
                if (got.last !== want.last)
                begin
                    $error("last_entry: expected %0d, got %0d", want.last, got.last);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic push_load(input int r, input int c, input logic [31:0] v);
        solver_word_t w;
        w.kind   = KIND_LOAD;
        w.row    = r[3:0];
        w.column = c[4:0];
        w.coef   = v;
        pending_words.push_back(w);
        item_count++;
    endtask

    task automatic push_solve();
        solver_word_t w;
        w.kind   = KIND_SOLVE;
        w.row    = 4'($urandom);
        w.column = 5'($urandom);
        w.coef   = $urandom;
        pending_words.push_back(w);
        item_count++;
    endtask

    // Hold until the block has drained, then let it settle
    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_words.size() != 0 || s_tvalid || expected_solutions.size() != 0);
        repeat (12) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [30:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_TOLERANCE: tol_reg   = val;
            CFG_SIZE:      size_reg  = val[4:0];
            CFG_LIMIT:     limit_reg = val[15:0];
            default: ;
        endcase
    endtask

    function automatic logic [31:0] fill_value(input int fill, input int r, input int c, input int n);
        if (fill == FILL_RANDOM)
            return $urandom;
        if (c == r)
        begin
            if (fill == FILL_ZERO_DIAG && r == n - 1)
                return 32'd0;
            return ($urandom_range(1) ? 32'd1 : -32'd1) * $urandom_range(32'h100000, 32'h1000000);
        end
        if (c == n)
            return $signed($urandom_range(32'h200000)) - 32'sh100000;
        return $signed($urandom_range(32'h20000)) - 32'sh10000;
    endfunction

    // One phase: set registers, load every entry in use plus some noise, solve
    task automatic run_phase(input logic [30:0] tol, input logic [4:0] size_raw,
                             input logic [15:0] lim, input int fill);
        int n;
        wait_drained();
        write_reg(CFG_TOLERANCE, tol);
        write_reg(CFG_SIZE, 31'(size_raw));
        write_reg(CFG_LIMIT, 31'(lim));
        n = (size_raw == 0) ? 1 : (size_raw > MAX_UNKNOWNS) ? MAX_UNKNOWNS : size_raw;
        @(negedge clk);
        for (int r = 0; r < n; r++)
            for (int c = 0; c <= n; c++)
                push_load(r, c, fill_value(fill, r, c, n));
        // ignored or unused loads
        repeat ($urandom_range(3))
        begin
            if ($urandom_range(1))
                push_load($urandom_range(15), $urandom_range(17, 31), $urandom);
            else if (n < MAX_UNKNOWNS)
                push_load($urandom_range(15), $urandom_range(n + 1, MAX_UNKNOWNS), $urandom);
        end
        push_solve();
    endtask

    initial
    begin
        int n;
        rst_n         = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        calm          = 1'b0;
        long_hold_req = 1'b0;
        fail_count    = 0;
        item_count    = 0;
        solve_count   = 0;
        result_count  = 0;
        cycle_count   = 0;
        status_seen   = '{0, 0, 0};
        tol_reg       = 31'd66;
        size_reg      = 5'd16;
        limit_reg     = 16'd1000;
        for (int r = 0; r < MAX_UNKNOWNS; r++)
            for (int c = 0; c < ROW_LEN; c++)
                coef_mem[r][c] = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: saturating quotients, zero tolerance, largest limit
        wait_drained();
        write_reg(CFG_TOLERANCE, 31'd0);
        write_reg(CFG_SIZE, 31'd2);
        write_reg(CFG_LIMIT, 31'd65535);
        @(negedge clk);
        push_load(0, 0, 32'h0001_0000);
        push_load(0, 1, 32'h0000_0000);
        push_load(0, 2, 32'h7FFF_FFFF);
        push_load(1, 0, 32'h8000_0000);
        push_load(1, 1, 32'hFFFF_FFFF);
        push_load(1, 2, 32'h8000_0000);
        push_load(15, 31, 32'hFFFF_FFFF);
        push_load(15, 16, 32'h0);
        push_solve();
        // Directed: zero diagonal
        wait_drained();
        push_load(1, 1, 32'h0);
        push_solve();
        // Directed: coupled extremes with a single sweep
        wait_drained();
        write_reg(CFG_LIMIT, 31'd1);
        @(negedge clk);
        push_load(0, 1, 32'h8000_0000);
        push_load(1, 1, 32'h8000_0000);
        push_load(1, 0, 32'h7FFF_FFFF);
        push_solve();

        // Register extremes: size 0 acts as one, oversize acts as full size
        run_phase(31'h7FFF_FFFF, 5'd0, 16'd0, FILL_RANDOM);
        calm = 1'b1;
        run_phase(31'h7FFF_FFFF, 5'd31, 16'd0, FILL_DOMINANT);
        calm = 1'b0;
        run_phase(31'd0, 5'd16, 16'd2, FILL_DOMINANT);

        // Random phases, mostly small systems
        while (item_count < ITEM_TARGET)
        begin
            logic [30:0] tol;
            logic [15:0] lim;
            int fill;
            n = ($urandom_range(9) == 0) ? $urandom_range(5, 8) : $urandom_range(1, 4);
            case ($urandom_range(3))
                0: tol = 31'd0;
                1: tol = 31'($urandom);
                default: tol = 31'($urandom_range(4096));
            endcase
            lim = ($urandom_range(11) == 0) ? 16'd0 : 16'($urandom_range(1, 25));
            fill = ($urandom_range(5) == 0) ? FILL_ZERO_DIAG
                 : ($urandom_range(2) == 0) ? FILL_RANDOM : FILL_DOMINANT;
            if (solve_count == 12)
                long_hold_req = 1'b1;
            calm = (solve_count % 9 == 4);
            run_phase(tol, 5'(n), lim, fill);
        end

        wait_drained();
        repeat (200) @(negedge clk);
        $display("ran %0d solves from %0d input words, checked %0d solution words",
                 solve_count, item_count, result_count);
        $display("status mix: %0d converged, %0d at limit, %0d zero diagonal",
                 status_seen[0], status_seen[1], status_seen[2]);
        if (fail_count == 0 && expected_solutions.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

@@ files.f @@
rtl/core/jls_pkg.sv
rtl/core/jls_div.sv
rtl/core/jacobi_linear_solver_top.sv
sim/jacobi_linear_solver_top_tb.sv
